### rtl/pwl_pkg.sv
// shared widths, sizes and codes of the piecewise linear interpolation unit
`default_nettype none

package pwl_pkg;

  localparam int MAX_POINTS = 32;
  localparam int NUM_TABLES = 3;
  localparam int CFG_TABLES = 3;
  localparam int NUM_VALID  = (NUM_TABLES < CFG_TABLES) ? NUM_TABLES : CFG_TABLES;

  localparam int X_W      = 16;
  localparam int Y_W      = 20;
  localparam int SEL_W    = 2;
  localparam int ENTRY_W  = 5;
  localparam int CNT_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = X_W + Y_W;
  localparam int IDX_W    = $clog2(MAX_POINTS);
  localparam int DEPTH    = NUM_TABLES * MAX_POINTS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int BP_W     = X_W + Y_W;
  localparam int STEP_W   = 5;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_BAD_SEL = 1'b1;

  typedef struct packed {
    logic             start;
    logic [X_W-1:0]   off;
    logic [X_W-1:0]   dx;
    logic [Y_W-1:0]   dy_mag;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [Y_W-1:0]   quo;
  } md_rsp_t;

endpackage

`default_nettype wire

### rtl/pwl_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module pwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/pwl_muldiv.sv
// bit-serial multiply of offset by slope magnitude, then restoring divide by segment width
`default_nettype none

module pwl_muldiv (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pwl_pkg::md_req_t req_i,
  output pwl_pkg::md_rsp_t      rsp_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [pwl_pkg::STEP_W-1:0]     cnt_q, cnt_d;
  logic [pwl_pkg::PROD_W-1:0]     acc_q, acc_d;
  logic [pwl_pkg::X_W-1:0]        opnd_q, opnd_d;
  logic [pwl_pkg::X_W-1:0]        dx_q, dx_d;
  logic [pwl_pkg::Y_W-1:0]        mag_q, mag_d;
  logic [pwl_pkg::X_W-1:0]        rem_q, rem_d;
  logic                           done_q, done_d;
  logic [pwl_pkg::PROD_W-1:0]     mul_next;
  logic [pwl_pkg::X_W:0]          trial;
  logic                           ge;

  assign mul_next = {acc_q[pwl_pkg::PROD_W-2:0], 1'b0}
                  + (opnd_q[pwl_pkg::X_W-1] ? pwl_pkg::PROD_W'(mag_q)
                                            : pwl_pkg::PROD_W'(0));
  assign trial = {rem_q, acc_q[pwl_pkg::Y_W-1]};
  assign ge    = (trial >= {1'b0, dx_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    opnd_d  = opnd_q;
    dx_d    = dx_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          acc_d   = '0;
          opnd_d  = req_i.off;
          dx_d    = req_i.dx;
          mag_d   = req_i.dy_mag;
          cnt_d   = pwl_pkg::STEP_W'(pwl_pkg::X_W - 1);
          state_d = M_MUL;
        end
      end
      M_MUL: begin
        acc_d  = mul_next;
        opnd_d = {opnd_q[pwl_pkg::X_W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d   = mul_next[pwl_pkg::PROD_W-1:pwl_pkg::Y_W];
          cnt_d   = pwl_pkg::STEP_W'(pwl_pkg::Y_W - 1);
          state_d = M_DIV;
        end
      end
      M_DIV: begin
        rem_d = ge ? pwl_pkg::X_W'(trial - {1'b0, dx_q}) : trial[pwl_pkg::X_W-1:0];
        acc_d = {acc_q[pwl_pkg::PROD_W-1:pwl_pkg::Y_W],
                 acc_q[pwl_pkg::Y_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = M_IDLE;
        end
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
    dx_q   <= dx_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = acc_q[pwl_pkg::Y_W-1:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == M_IDLE)
    else $error("muldiv started while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == M_DIV |-> rem_q < dx_q)
    else $error("partial remainder not below divisor");

  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == M_DIV)
    else $error("done without divide phase");

endmodule

`default_nettype wire

### rtl/pwl_ctrl.sv
// command decode, breakpoint writes and segment search sequencer
`default_nettype none

module pwl_ctrl (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          start,
  output logic                                               busy,
  input  wire logic                                          op_i,
  input  wire logic [pwl_pkg::SEL_W-1:0]                     table_sel_i,
  input  wire logic [pwl_pkg::ENTRY_W-1:0]                   entry_index_i,
  input  wire logic [pwl_pkg::X_W-1:0]                       x_value_i,
  input  wire logic signed [pwl_pkg::Y_W-1:0]                y_value_i,
  input  wire logic [pwl_pkg::CFG_TABLES-1:0][pwl_pkg::CNT_W-1:0] points_i,
  output logic                                               ram_we_o,
  output logic [pwl_pkg::ADDR_W-1:0]                         ram_waddr_o,
  output logic [pwl_pkg::BP_W-1:0]                           ram_wdata_o,
  output logic [pwl_pkg::ADDR_W-1:0]                         ram_raddr_o,
  input  wire logic [pwl_pkg::BP_W-1:0]                      ram_rdata_i,
  output pwl_pkg::md_req_t                                   md_req_o,
  input  wire pwl_pkg::md_rsp_t                              md_rsp_i,
  output logic                                               done_o,
  output logic signed [pwl_pkg::Y_W-1:0]                     result_value_o,
  output logic                                               status_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  function automatic logic [pwl_pkg::IDX_W-1:0] last_index(
    input logic [pwl_pkg::CNT_W-1:0] cnt
  );
    int n;
    n = int'(cnt);
    if (n < 1) n = 1;
    if (n > pwl_pkg::MAX_POINTS) n = pwl_pkg::MAX_POINTS;
    return pwl_pkg::IDX_W'(n - 1);
  endfunction

  logic [2:0]                    state_q, state_d;
  logic [pwl_pkg::SEL_W-1:0]     sel_q, sel_d;
  logic [pwl_pkg::X_W-1:0]       x_q, x_d;
  logic [pwl_pkg::IDX_W-1:0]     last_q, last_d;
  logic [pwl_pkg::IDX_W-1:0]     k_q, rd_idx;
  logic [pwl_pkg::X_W-1:0]       px_q, px_d;
  logic [pwl_pkg::Y_W-1:0]       py_q, py_d;
  logic                          neg_q, neg_d;
  pwl_pkg::md_req_t              req_q, req_d;
  logic                          done_q, done_d;
  logic [pwl_pkg::Y_W-1:0]       res_q, res_d;
  logic                          stat_q, stat_d;

  logic                          accept;
  logic                          sel_ok;
  logic [pwl_pkg::SEL_W-1:0]     rd_sel;
  logic [pwl_pkg::X_W-1:0]       rx;
  logic [pwl_pkg::Y_W-1:0]       ry;
  logic [pwl_pkg::Y_W:0]         dy;
  logic [pwl_pkg::Y_W:0]         dy_abs;
  logic [pwl_pkg::Y_W:0]         q_signed;
  logic [pwl_pkg::Y_W:0]         sum;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign sel_ok = (int'(table_sel_i) < pwl_pkg::NUM_VALID);

  assign ram_we_o    = accept && (op_i == pwl_pkg::OP_WRITE) && sel_ok
                       && (int'(entry_index_i) < pwl_pkg::MAX_POINTS);
  assign ram_waddr_o = pwl_pkg::ADDR_W'(int'(table_sel_i) * pwl_pkg::MAX_POINTS
                                        + int'(entry_index_i));
  assign ram_wdata_o = {x_value_i, y_value_i};

  assign rd_sel      = busy ? sel_q : table_sel_i;
  assign ram_raddr_o = pwl_pkg::ADDR_W'(int'(rd_sel) * pwl_pkg::MAX_POINTS + int'(rd_idx));

  assign rx = ram_rdata_i[pwl_pkg::BP_W-1:pwl_pkg::Y_W];
  assign ry = ram_rdata_i[pwl_pkg::Y_W-1:0];

  assign dy       = {ry[pwl_pkg::Y_W-1], ry} - {py_q[pwl_pkg::Y_W-1], py_q};
  assign dy_abs   = dy[pwl_pkg::Y_W] ? (~dy + 1'b1) : dy;
  assign q_signed = neg_q ? (~{1'b0, md_rsp_i.quo} + 1'b1) : {1'b0, md_rsp_i.quo};
  assign sum      = {py_q[pwl_pkg::Y_W-1], py_q} + q_signed;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    x_d     = x_q;
    last_d  = last_q;
    rd_idx  = '0;
    px_d    = px_q;
    py_d    = py_q;
    neg_d   = neg_q;
    req_d   = req_q;
    req_d.start = 1'b0;
    done_d  = 1'b0;
    res_d   = res_q;
    stat_d  = stat_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sel_d  = table_sel_i;
          x_d    = x_value_i;
          last_d = last_index(points_i[table_sel_i]);
          if (!sel_ok) begin
            done_d = 1'b1;
            res_d  = '0;
            stat_d = pwl_pkg::ST_BAD_SEL;
          end else if (op_i == pwl_pkg::OP_WRITE) begin
            done_d = 1'b1;
            res_d  = '0;
            stat_d = pwl_pkg::ST_OK;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if ((x_q < rx) || (last_q == '0)) begin
          done_d  = 1'b1;
          res_d   = ry;
          stat_d  = pwl_pkg::ST_OK;
          state_d = S_IDLE;
        end else begin
          px_d    = rx;
          py_d    = ry;
          rd_idx  = last_q;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (x_q >= rx) begin
          done_d  = 1'b1;
          res_d   = ry;
          stat_d  = pwl_pkg::ST_OK;
          state_d = S_IDLE;
        end else begin
          rd_idx  = pwl_pkg::IDX_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (x_q < rx) begin
          req_d.start  = 1'b1;
          req_d.off    = x_q - px_q;
          req_d.dx     = rx - px_q;
          req_d.dy_mag = dy_abs[pwl_pkg::Y_W-1:0];
          neg_d        = dy[pwl_pkg::Y_W];
          state_d      = S_WAIT;
        end else begin
          px_d   = rx;
          py_d   = ry;
          rd_idx = k_q + 1'b1;
        end
      end
      S_WAIT: begin
        if (md_rsp_i.done) begin
          done_d  = 1'b1;
          res_d   = sum[pwl_pkg::Y_W-1:0];
          stat_d  = pwl_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q        <= sel_d;
    x_q          <= x_d;
    last_q       <= last_d;
    k_q          <= rd_idx;
    px_q         <= px_d;
    py_q         <= py_d;
    neg_q        <= neg_d;
    res_q        <= res_d;
    stat_q       <= stat_d;
  end

  assign md_req_o       = req_q;
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = stat_q;

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ram_we_o)
    else $error("breakpoint write during lookup");

  a_md_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp_i.done |-> state_q == S_WAIT)
    else $error("unexpected muldiv done");

  a_bad_sel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (stat_q == pwl_pkg::ST_BAD_SEL)) |-> (res_q == '0))
    else $error("error word with nonzero value");

  a_req_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.start |-> $past(state_q) == S_SCAN)
    else $error("muldiv request outside search");

endmodule

`default_nettype wire

### rtl/piecewise_linear_table_interp_unit.sv
// top level of the piecewise linear table interpolation unit
`default_nettype none

// A command is taken when start is high and busy is low. op_i selects a
// lookup or a write of one breakpoint (x_value_i, y_value_i) at entry_index_i
// of table table_sel_i. Every command gives one result word: done_o is high
// for exactly one cycle with result_value_o and status_o, and the receiver
// cannot hold it off. Writes and invalid table selects answer in the next
// cycle and busy stays low, so they may follow each other every cycle.
// A lookup reads the breakpoint ram one entry per cycle: first entry, last
// entry, then a scan from entry 1 up to the segment found, followed by a
// bit-serial multiply and a restoring divide. A lookup clamped at the first
// or last point answers without the scan, multiply and divide; busy is high
// throughout. The point counts are written through the port cfg_we_i /
// cfg_idx_i / cfg_wdata_i; the user must write them only while idle, which
// the block itself does not enforce. Index 3 is ignored. Reset clears
// control state and sets the counts to 3, 3 and 30; the breakpoint ram is
// not cleared and must be written before it is read.

module piecewise_linear_table_interp_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [pwl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [pwl_pkg::CNT_W-1:0]            cfg_wdata_i,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 op_i,
  input  wire logic [pwl_pkg::SEL_W-1:0]            table_sel_i,
  input  wire logic [pwl_pkg::ENTRY_W-1:0]          entry_index_i,
  input  wire logic [pwl_pkg::X_W-1:0]              x_value_i,
  input  wire logic signed [pwl_pkg::Y_W-1:0]       y_value_i,
  output logic                                      done_o,
  output logic signed [pwl_pkg::Y_W-1:0]            result_value_o,
  output logic                                      status_o
);

  localparam logic [pwl_pkg::CNT_W-1:0] RESET_PTS0 = pwl_pkg::CNT_W'(3);
  localparam logic [pwl_pkg::CNT_W-1:0] RESET_PTS1 = pwl_pkg::CNT_W'(3);
  localparam logic [pwl_pkg::CNT_W-1:0] RESET_PTS2 = pwl_pkg::CNT_W'(30);

  logic [pwl_pkg::CFG_TABLES-1:0][pwl_pkg::CNT_W-1:0] points_q;
  logic                           ram_we;
  logic [pwl_pkg::ADDR_W-1:0]     ram_waddr;
  logic [pwl_pkg::BP_W-1:0]       ram_wdata;
  logic [pwl_pkg::ADDR_W-1:0]     ram_raddr;
  logic [pwl_pkg::BP_W-1:0]       ram_rdata;
  pwl_pkg::md_req_t               md_req;
  pwl_pkg::md_rsp_t               md_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q[0] <= RESET_PTS0;
      points_q[1] <= RESET_PTS1;
      points_q[2] <= RESET_PTS2;
    end else if (cfg_we_i && (int'(cfg_idx_i) < pwl_pkg::CFG_TABLES)) begin
      points_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  pwl_ram #(
    .WIDTH (pwl_pkg::BP_W),
    .DEPTH (pwl_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pwl_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  pwl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .table_sel_i    (table_sel_i),
    .entry_index_i  (entry_index_i),
    .x_value_i      (x_value_i),
    .y_value_i      (y_value_i),
    .points_i       (points_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .md_req_o       (md_req),
    .md_rsp_i       (md_rsp),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

### sim/tb_piecewise_linear_table_interp_unit.sv
// testbench of the piecewise linear table interpolation unit: directed rows and random words
`default_nettype none

module tb_piecewise_linear_table_interp_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 200;
  localparam int SHOWN_MISMATCHES = 10;

  localparam logic [pwl_pkg::CFG_IDX_W-1:0] REG_POINTS_T0 = 2'd0;
  localparam logic [pwl_pkg::CFG_IDX_W-1:0] REG_POINTS_T2 = 2'd2;
  localparam logic [pwl_pkg::CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
  localparam logic [pwl_pkg::SEL_W-1:0]     SEL_INVALID   = 2'd3;

  localparam logic signed [pwl_pkg::Y_W-1:0] Y_LO = {1'b1, {(pwl_pkg::Y_W-1){1'b0}}};
  localparam logic signed [pwl_pkg::Y_W-1:0] Y_HI = {1'b0, {(pwl_pkg::Y_W-1){1'b1}}};

  typedef struct {
    logic                           op;
    logic [pwl_pkg::SEL_W-1:0]      sel;
    logic [pwl_pkg::ENTRY_W-1:0]    idx;
    logic [pwl_pkg::X_W-1:0]        x;
    logic signed [pwl_pkg::Y_W-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic signed [pwl_pkg::Y_W-1:0] value;
    logic                           status;
  } answer_t;

  typedef struct {
    cmd_t    cmd;
    bit      typed;
    answer_t ans;
  } row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [pwl_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [pwl_pkg::CNT_W-1:0]       cfg_wdata_i = '0;
  logic                            start = 1'b0;
  logic                            busy;
  logic                            op_i = pwl_pkg::OP_LOOKUP;
  logic [pwl_pkg::SEL_W-1:0]       table_sel_i = '0;
  logic [pwl_pkg::ENTRY_W-1:0]     entry_index_i = '0;
  logic [pwl_pkg::X_W-1:0]         x_value_i = '0;
  logic signed [pwl_pkg::Y_W-1:0]  y_value_i = '0;
  logic                            done_o;
  logic signed [pwl_pkg::Y_W-1:0]  result_value_o;
  logic                            status_o;

  logic [pwl_pkg::X_W-1:0]        pt_x [pwl_pkg::NUM_VALID][pwl_pkg::MAX_POINTS];
  logic signed [pwl_pkg::Y_W-1:0] pt_y [pwl_pkg::NUM_VALID][pwl_pkg::MAX_POINTS];
  bit                             pt_set [pwl_pkg::NUM_VALID][pwl_pkg::MAX_POINTS];
  logic [pwl_pkg::CNT_W-1:0]      pt_count [pwl_pkg::NUM_VALID] = '{6'd3, 6'd3, 6'd30};

  answer_t due_results [$];
  answer_t want;
  row_t    plan [$];
  int      bad_words = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  bit      gaps_on = 1'b1;

  piecewise_linear_table_interp_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .table_sel_i    (table_sel_i),
    .entry_index_i  (entry_index_i),
    .x_value_i      (x_value_i),
    .y_value_i      (y_value_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int used_points(input int t);
    int v;
    v = pt_count[t];
    if (v < 1) return 1;
    if (v > pwl_pkg::MAX_POINTS) return pwl_pkg::MAX_POINTS;
    return v;
  endfunction

  function automatic bit table_ready(input int t);
    for (int k = 0; k < used_points(t); k++) begin
      if (!pt_set[t][k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic answer_t interpolate_word(input cmd_t c);
    answer_t a;
    int      s;
    int      n;
    bit      hit;
    longint  off;
    longint  dx;
    longint  dy;
    a.value = '0;
    a.status = pwl_pkg::ST_OK;
    s = int'(c.sel);
    if (s >= pwl_pkg::NUM_VALID) begin
      a.status = pwl_pkg::ST_BAD_SEL;
      return a;
    end
    if (c.op == pwl_pkg::OP_WRITE) begin
      pt_x[s][c.idx] = c.x;
      pt_y[s][c.idx] = c.y;
      pt_set[s][c.idx] = 1'b1;
      return a;
    end
    n = used_points(s);
    if (c.x < pt_x[s][0]) begin
      a.value = pt_y[s][0];
    end else if (c.x >= pt_x[s][n-1]) begin
      a.value = pt_y[s][n-1];
    end else begin
      hit = 1'b0;
      a.value = pt_y[s][n-1];
      for (int k = 0; k + 1 < n; k++) begin
        if (!hit && c.x < pt_x[s][k+1]) begin
          hit = 1'b1;
          off = longint'(c.x) - longint'(pt_x[s][k]);
          dx = longint'(pt_x[s][k+1]) - longint'(pt_x[s][k]);
          dy = longint'(pt_y[s][k+1]) - longint'(pt_y[s][k]);
          a.value = pwl_pkg::Y_W'(longint'(pt_y[s][k]) + off * dy / dx);
        end
      end
    end
    return a;
  endfunction

  function automatic row_t row(input logic op, input logic [pwl_pkg::SEL_W-1:0] sel,
                               input logic [pwl_pkg::ENTRY_W-1:0] idx,
                               input logic [pwl_pkg::X_W-1:0] x,
                               input logic signed [pwl_pkg::Y_W-1:0] y, input bit typed,
                               input logic signed [pwl_pkg::Y_W-1:0] value,
                               input logic status);
    row_t r;
    r.cmd.op = op;
    r.cmd.sel = sel;
    r.cmd.idx = idx;
    r.cmd.x = x;
    r.cmd.y = y;
    r.typed = typed;
    r.ans.value = value;
    r.ans.status = status;
    return r;
  endfunction

  function automatic logic signed [pwl_pkg::Y_W-1:0] pick_y();
    case ($urandom_range(7))
      0: return Y_LO;
      1: return Y_HI;
      2: return '0;
      default: return pwl_pkg::Y_W'($urandom);
    endcase
  endfunction

  function automatic logic [pwl_pkg::X_W-1:0] pick_x(input int t);
    int                      n;
    int                      k;
    logic [pwl_pkg::X_W-1:0] lo;
    logic [pwl_pkg::X_W-1:0] hi;
    n = used_points(t);
    k = $urandom_range(n - 1);
    lo = pt_x[t][k];
    hi = (k + 1 < n) ? pt_x[t][k+1] : lo;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return pwl_pkg::X_W'($urandom);
      4: return lo;
      default: return (hi > lo) ? pwl_pkg::X_W'($urandom_range(int'(hi) - 1, int'(lo))) : lo;
    endcase
  endfunction

  task automatic pause();
    int len;
    if (gaps_on && $urandom_range(99) < 16) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(80, 1) : $urandom_range(3, 1);
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic issue(input cmd_t c, input bit typed, input answer_t typed_ans);
    answer_t a;
    start <= 1'b1;
    op_i <= c.op;
    table_sel_i <= c.sel;
    entry_index_i <= c.idx;
    x_value_i <= c.x;
    y_value_i <= c.y;
    do @(posedge clk_i); while (busy);
    a = interpolate_word(c);
    due_results.push_back(typed ? typed_ans : a);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0 || busy);
  endtask

  task automatic load_counts(input logic [pwl_pkg::CNT_W-1:0] v [pwl_pkg::NUM_VALID]);
    for (int i = REG_POINTS_T0; i <= REG_SPARE; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= pwl_pkg::CFG_IDX_W'(i);
      cfg_wdata_i <= (i <= REG_POINTS_T2) ? v[i] : pwl_pkg::CNT_W'($urandom);
      @(posedge clk_i);
      if (i <= REG_POINTS_T2) pt_count[i] = v[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  // sorted breakpoints, wide or packed into a narrow x window
  task automatic reload_table(input int t);
    int                      cnt;
    int                      lo;
    int                      hi;
    cmd_t                    c;
    logic [pwl_pkg::X_W-1:0] xs [$];
    cnt = $urandom_range(1) ? pwl_pkg::MAX_POINTS : used_points(t);
    if ($urandom_range(1)) begin
      lo = 0;
      hi = 65535;
    end else begin
      lo = $urandom_range(65535 - 64);
      hi = lo + $urandom_range(2000, 4);
      if (hi > 65535) hi = 65535;
    end
    repeat (cnt) xs.push_back(pwl_pkg::X_W'($urandom_range(hi, lo)));
    xs.sort();
    foreach (xs[k]) begin
      c.op = pwl_pkg::OP_WRITE;
      c.sel = pwl_pkg::SEL_W'(t);
      c.idx = pwl_pkg::ENTRY_W'(k);
      c.x = xs[k];
      c.y = pick_y();
      pause();
      issue(c, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (due_results.size() == 0) begin
        bad_words++;
        if (bad_words <= SHOWN_MISMATCHES) begin
          $display("unexpected word: value %0d status %0d", result_value_o, status_o);
        end
      end else begin
        want = due_results.pop_front();
        if (result_value_o !== want.value || status_o !== want.status) begin
          bad_words++;
          if (bad_words <= SHOWN_MISMATCHES) begin
            $display("word mismatch: value exp %0d got %0d, status exp %0d got %0d",
                     want.value, result_value_o, want.status, status_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_piecewise_linear_table_interp_unit: FAIL");
      $finish;
    end
  end

  initial begin
    cmd_t                      c;
    logic [pwl_pkg::CNT_W-1:0] counts [pwl_pkg::NUM_VALID];
    int                        t;
    int                        roll;
    int                        phase_end;

    plan.push_back(row(pwl_pkg::OP_LOOKUP, SEL_INVALID, 5'd0, 16'h0000, '0,
                       1'b1, '0, pwl_pkg::ST_BAD_SEL));
    plan.push_back(row(pwl_pkg::OP_WRITE, SEL_INVALID, 5'd31, 16'hFFFF, '1,
                       1'b1, '0, pwl_pkg::ST_BAD_SEL));
    plan.push_back(row(pwl_pkg::OP_WRITE, 2'd0, 5'd0, 16'h0100, Y_LO,
                       1'b1, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_WRITE, 2'd0, 5'd1, 16'h0800, Y_HI,
                       1'b1, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_WRITE, 2'd0, 5'd2, 16'hFFFF, '0,
                       1'b1, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd0, 5'd0, 16'h0000, '0,
                       1'b1, Y_LO, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd0, 5'd31, 16'h0100, '1,
                       1'b1, Y_LO, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd0, 5'd0, 16'h0400, '0,
                       1'b0, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd0, 5'd0, 16'h0800, '0,
                       1'b1, Y_HI, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd0, 5'd0, 16'hFFFE, '0,
                       1'b0, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd0, 5'd0, 16'hFFFF, '0,
                       1'b1, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_WRITE, 2'd0, 5'd31, 16'hFFFF, Y_LO,
                       1'b1, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_WRITE, 2'd1, 5'd0, 16'h2000, 20'sh00100,
                       1'b1, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_WRITE, 2'd1, 5'd1, 16'h2000, 20'sh00200,
                       1'b1, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_WRITE, 2'd1, 5'd2, 16'h2000, 20'sh00300,
                       1'b1, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd1, 5'd0, 16'h1FFF, '0,
                       1'b1, 20'sh00100, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd1, 5'd0, 16'h2000, '0,
                       1'b1, 20'sh00300, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_WRITE, 2'd1, 5'd1, 16'h3000, Y_LO,
                       1'b0, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, 2'd1, 5'd0, 16'h2800, '0,
                       1'b0, '0, pwl_pkg::ST_OK));
    plan.push_back(row(pwl_pkg::OP_LOOKUP, SEL_INVALID, 5'd31, 16'hFFFF, Y_LO,
                       1'b1, '0, pwl_pkg::ST_BAD_SEL));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      pause();
      issue(plan[k].cmd, plan[k].typed, plan[k].ans);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      gaps_on = (ph != 3);
      case (ph)
        0: counts = '{6'd0, 6'd32, 6'd63};
        1: counts = '{6'd1, 6'd2, 6'd33};
        2: counts = '{6'd32, 6'd1, 6'd2};
        3: counts = '{6'd2, 6'd63, 6'd32};
        default: begin
          foreach (counts[i]) begin
            counts[i] = ($urandom_range(3) == 0) ? pwl_pkg::CNT_W'($urandom) :
                        pwl_pkg::CNT_W'($urandom_range(12, 1));
          end
        end
      endcase
      load_counts(counts);
      phase_end = items_sent + PHASE_WORDS;
      for (t = 0; t < pwl_pkg::NUM_VALID; t++) begin
        if (!table_ready(t) || $urandom_range(1) == 0) reload_table(t);
      end
      while (items_sent < phase_end) begin
        roll = $urandom_range(99);
        t = $urandom_range(pwl_pkg::NUM_VALID - 1);
        c.op = pwl_pkg::OP_LOOKUP;
        c.sel = pwl_pkg::SEL_W'(t);
        c.idx = pwl_pkg::ENTRY_W'($urandom);
        c.x = pwl_pkg::X_W'($urandom);
        c.y = pick_y();
        if (roll < 8) begin
          c.op = 1'($urandom);
          c.sel = SEL_INVALID;
        end else if (roll < 22) begin
          c.op = pwl_pkg::OP_WRITE;
        end else if (roll < 26 || !table_ready(t)) begin
          reload_table(t);
          continue;
        end else begin
          c.x = pick_x(t);
        end
        pause();
        issue(c, 1'b0, '0);
      end
    end

    settle();
    repeat (80) @(posedge clk_i);
    if (bad_words == 0) begin
      $display("tb_piecewise_linear_table_interp_unit: PASS");
    end else begin
      $display("tb_piecewise_linear_table_interp_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
